// ===== rtl/ptc_pkg.sv =====
`timescale 1ns / 1ps

package ptc_pkg;

   localparam int RAW_W   = 24;
   localparam int CAL_W   = 16;
   localparam int BIAS_W  = 16;
   localparam int TEMP_W  = 19;
   localparam int PRES_W  = 18;
   localparam int CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SENS_T1  = 3'd0,
      CSR_OFF_T1   = 3'd1,
      CSR_TCS      = 3'd2,
      CSR_TCO      = 3'd3,
      CSR_TREF     = 3'd4,
      CSR_TEMPSENS = 3'd5
   } csr_index_type;

   localparam logic signed [TEMP_W-1:0] TEMP_BASE = 19'sd2000;

   // floor(x / 100) == (x * DIV100_MULT) >> DIV100_SHIFT for any x below 2**25
   localparam int DIV100_SHIFT = 32;
   localparam logic [25:0] DIV100_MULT = 26'd42949673;

endpackage

// ===== rtl/pressure_temperature_compensation.sv =====
// Barometric first-order compensation pipeline.
// Input: drive req_raw_pres, req_raw_temp and req_pres_bias_mbar with start high;
// the transaction is taken at any rising edge with start high and busy low.
// busy stays low, so one transaction can be issued every cycle.
// Output: rsp_valid pulses for one cycle with rsp_temp_centi (0.01 degC) and
// rsp_pressure (mbar, bias removed). Results come out in issue order.
// The receiver cannot stall the pipeline; results must be taken when strobed.
// Throughput is one transaction per cycle; the pipeline has eleven register
// stages (the wide 24x36 pressure product is split over two of them,
// and the signed divide by 100 uses a reciprocal multiply stage).
// Calibration: six 16-bit words written over csr_valid/csr_ready/csr_index/
// csr_wdata; csr_ready is always high, indexes past the last word are ignored.
// Write calibration only while no transaction is in flight.
// Reset (synchronous, active high) clears calibration to zero and drops all
// in-flight transactions.
`timescale 1ns / 1ps

module pressure_temperature_compensation
   import ptc_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [RAW_W-1:0]            req_raw_pres,
   input  logic [RAW_W-1:0]            req_raw_temp,
   input  logic signed [BIAS_W-1:0]    req_pres_bias_mbar,
   output logic                        rsp_valid,
   output logic signed [TEMP_W-1:0]    rsp_temp_centi,
   output logic signed [PRES_W-1:0]    rsp_pressure,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CAL_W-1:0]            csr_wdata
);

   localparam int STAGES   = 11;
   localparam int BIAS_DLY = 10;   // stages 1..10
   localparam int TEMP_DLY = 8;    // stages 3..10
   localparam int OFF_DLY  = 4;    // stages 3..6
   localparam int D1_DLY   = 3;    // stages 1..3

   // calibration
   logic [CAL_W-1:0] sens_t1_ff, off_t1_ff, tcs_ff, tco_ff, tref_ff, tempsens_ff;

   logic [STAGES-1:0] valid_ff;

   logic [RAW_W-1:0]          d1_dly_ff   [D1_DLY];
   logic signed [BIAS_W-1:0]  bias_dly_ff [BIAS_DLY];
   logic signed [TEMP_W-1:0]  temp_dly_ff [TEMP_DLY];
   logic signed [36:0]        off_dly_ff  [OFF_DLY];

   logic signed [24:0] dt_ff, dt_in;
   logic signed [41:0] pt_ff, po_ff, ps_ff, pt_in, po_in, ps_in;
   logic signed [41:0] pt_adj, po_adj, ps_adj;
   logic signed [TEMP_W-1:0] temp_in;
   logic signed [36:0] off_in;
   logic signed [35:0] sens_ff, sens_in;
   logic [41:0]        plo_ff, plo_in;
   logic signed [42:0] phi_ff, phi_in;
   logic signed [60:0] p_ff, p_in, p_adj;
   logic signed [39:0] q_ff, q_in, diff_ff, diff_in, diff_adj;
   logic signed [24:0] pa_ff, pa_in;
   logic [24:0]        mag_ff, mag_in;
   logic [50:0]        prod_ff, prod_in;
   logic [1:0]         neg_ff;
   logic [18:0]        quo;
   logic signed [19:0] quo_s;
   logic signed [TEMP_W-1:0] temp_out_ff;
   logic signed [PRES_W-1:0] pres_out_ff, pres_in;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_comb begin
      dt_in = $signed({1'b0, req_raw_temp}) - $signed({1'b0, tref_ff, 8'd0});

      pt_in = dt_ff * $signed({1'b0, tempsens_ff});
      po_in = dt_ff * $signed({1'b0, tco_ff});
      ps_in = dt_ff * $signed({1'b0, tcs_ff});

      // truncating divides: add (2**k - 1) to negative values before the shift
      pt_adj  = pt_ff + $signed({19'd0, {23{pt_ff[41]}}});
      po_adj  = po_ff + $signed({36'd0, {6{po_ff[41]}}});
      ps_adj  = ps_ff + $signed({35'd0, {7{ps_ff[41]}}});
      temp_in = TEMP_W'(pt_adj >>> 23) + TEMP_BASE;
      off_in  = $signed({4'd0, off_t1_ff, 17'd0}) + 37'(po_adj >>> 6);
      sens_in = $signed({4'd0, sens_t1_ff, 16'd0}) + 36'(ps_adj >>> 7);

      // d1 * sens as two partial products
      plo_in = {18'd0, d1_dly_ff[D1_DLY-1]} * {24'd0, sens_ff[17:0]};
      phi_in = $signed({1'b0, d1_dly_ff[D1_DLY-1]}) * $signed(sens_ff[35:18]);
      p_in   = $signed({phi_ff, 18'd0}) + $signed({19'd0, plo_ff});

      p_adj = p_ff + $signed({40'd0, {21{p_ff[60]}}});
      q_in  = 40'(p_adj >>> 21);

      diff_in  = q_ff - 40'(off_dly_ff[OFF_DLY-1]);
      diff_adj = diff_ff + $signed({25'd0, {15{diff_ff[39]}}});
      pa_in    = 25'(diff_adj >>> 15);

      mag_in  = pa_ff[24] ? 25'(-pa_ff) : 25'(pa_ff);
      prod_in = {26'd0, mag_ff} * {25'd0, DIV100_MULT};

      quo     = prod_ff[50:DIV100_SHIFT];
      quo_s   = neg_ff[1] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
      pres_in = PRES_W'(quo_s - 20'(bias_dly_ff[BIAS_DLY-1]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         sens_t1_ff  <= '0;
         off_t1_ff   <= '0;
         tcs_ff      <= '0;
         tco_ff      <= '0;
         tref_ff     <= '0;
         tempsens_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[STAGES-2:0], start & ~busy};
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SENS_T1:  sens_t1_ff  <= csr_wdata;
               CSR_OFF_T1:   off_t1_ff   <= csr_wdata;
               CSR_TCS:      tcs_ff      <= csr_wdata;
               CSR_TCO:      tco_ff      <= csr_wdata;
               CSR_TREF:     tref_ff     <= csr_wdata;
               CSR_TEMPSENS: tempsens_ff <= csr_wdata;
               default: ;
            endcase
         end
      end

      // payload, no reset
      dt_ff   <= dt_in;
      pt_ff   <= pt_in;
      po_ff   <= po_in;
      ps_ff   <= ps_in;
      sens_ff <= sens_in;
      plo_ff  <= plo_in;
      phi_ff  <= phi_in;
      p_ff    <= p_in;
      q_ff    <= q_in;
      diff_ff <= diff_in;
      pa_ff   <= pa_in;
      mag_ff  <= mag_in;
      prod_ff <= prod_in;
      neg_ff  <= {neg_ff[0], pa_ff[24]};
      temp_out_ff <= temp_dly_ff[TEMP_DLY-1];
      pres_out_ff <= pres_in;

      d1_dly_ff[0]   <= req_raw_pres;
      bias_dly_ff[0] <= req_pres_bias_mbar;
      temp_dly_ff[0] <= temp_in;
      off_dly_ff[0]  <= off_in;
      for (int i = 1; i < D1_DLY; i++) begin
         d1_dly_ff[i] <= d1_dly_ff[i-1];
      end
      for (int i = 1; i < BIAS_DLY; i++) begin
         bias_dly_ff[i] <= bias_dly_ff[i-1];
      end
      for (int i = 1; i < TEMP_DLY; i++) begin
         temp_dly_ff[i] <= temp_dly_ff[i-1];
      end
      for (int i = 1; i < OFF_DLY; i++) begin
         off_dly_ff[i] <= off_dly_ff[i-1];
      end
   end

   assign rsp_valid      = valid_ff[STAGES-1];
   assign rsp_temp_centi = temp_out_ff;
   assign rsp_pressure   = pres_out_ff;

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import ptc_pkg::*;

   localparam int LATENCY      = 11;
   localparam int DRAIN_CYCLES = 2 * LATENCY;
   localparam int STALL_LIMIT  = 2000;
   localparam int PHASES       = 5;
   localparam int PHASE_ITEMS  = 100;

   // indexes past the last calibration word; writes there must be dropped
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_SPARE0 = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_SPARE1 = 3'd7;

   typedef struct {
      logic signed [TEMP_W-1:0] temp_centi;
      logic signed [PRES_W-1:0] pressure;
   } reading_type;

   typedef struct {
      bit                       is_csr;
      logic [CSR_IDX_W-1:0]     index;
      logic [CAL_W-1:0]         wdata;
      logic [RAW_W-1:0]         raw_pres;
      logic [RAW_W-1:0]         raw_temp;
      logic signed [BIAS_W-1:0] bias;
      bit                       typed;
      logic signed [TEMP_W-1:0] temp_centi;
      logic signed [PRES_W-1:0] pressure;
   } step_row_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic [RAW_W-1:0]         req_raw_pres = '0;
   logic [RAW_W-1:0]         req_raw_temp = '0;
   logic signed [BIAS_W-1:0] req_pres_bias_mbar = '0;
   logic                     rsp_valid;
   logic signed [TEMP_W-1:0] rsp_temp_centi;
   logic signed [PRES_W-1:0] rsp_pressure;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_W-1:0]     csr_index = '0;
   logic [CAL_W-1:0]         csr_wdata = '0;

   logic [CAL_W-1:0] cal_shadow [0:CSR_TEMPSENS];
   reading_type      pending_readings [$];
   step_row_type     directed [$];
   reading_type      head;
   int               errors = 0;
   int               stall_cycles = 0;
   bit               gaps_on = 1'b1;
   bit               req_on = 1'b0;
   bit               csr_on = 1'b0;

   pressure_temperature_compensation u_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_raw_pres       (req_raw_pres),
      .req_raw_temp       (req_raw_temp),
      .req_pres_bias_mbar (req_pres_bias_mbar),
      .rsp_valid          (rsp_valid),
      .rsp_temp_centi     (rsp_temp_centi),
      .rsp_pressure       (rsp_pressure),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // first-order compensation, all divides truncate toward zero
   function automatic reading_type compensate(input logic [RAW_W-1:0] p,
                                              input logic [RAW_W-1:0] t,
                                              input logic signed [BIAS_W-1:0] b);
      longint d_pres, d_temp, dt, temp, off, sens, pa, mbar;
      longint k_sens, k_off, k_tcs, k_tco, k_tref, k_tsens;
      reading_type r;
      d_pres  = p;
      d_temp  = t;
      k_sens  = cal_shadow[CSR_SENS_T1];
      k_off   = cal_shadow[CSR_OFF_T1];
      k_tcs   = cal_shadow[CSR_TCS];
      k_tco   = cal_shadow[CSR_TCO];
      k_tref  = cal_shadow[CSR_TREF];
      k_tsens = cal_shadow[CSR_TEMPSENS];
      dt   = d_temp - k_tref * 256;
      temp = 2000 + (dt * k_tsens) / 8388608;
      off  = k_off * 131072 + (k_tco * dt) / 64;
      sens = k_sens * 65536 + (k_tcs * dt) / 128;
      pa   = ((d_pres * sens) / 2097152 - off) / 32768;
      mbar = pa / 100 - b;
      r.temp_centi = temp[TEMP_W-1:0];
      r.pressure   = mbar[PRES_W-1:0];
      return r;
   endfunction

   function automatic void add_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CAL_W-1:0] data);
      step_row_type r;
      r = '{default: '0};
      r.is_csr = 1'b1;
      r.index  = idx;
      r.wdata  = data;
      directed.push_back(r);
   endfunction

   function automatic void add_reading(input logic [RAW_W-1:0] p, input logic [RAW_W-1:0] t,
                                       input logic signed [BIAS_W-1:0] b, input bit typed,
                                       input logic signed [TEMP_W-1:0] et,
                                       input logic signed [PRES_W-1:0] ep);
      step_row_type r;
      r = '{default: '0};
      r.raw_pres   = p;
      r.raw_temp   = t;
      r.bias       = b;
      r.typed      = typed;
      r.temp_centi = et;
      r.pressure   = ep;
      directed.push_back(r);
   endfunction

   function automatic logic [RAW_W-1:0] pick_raw();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         default: return RAW_W'($urandom);
      endcase
   endfunction

   function automatic logic signed [BIAS_W-1:0] pick_bias();
      case ($urandom_range(9))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         default: return BIAS_W'($urandom);
      endcase
   endfunction

   function automatic logic [CAL_W-1:0] pick_cal();
      case ($urandom_range(5))
         0: return '0;
         1: return '1;
         default: return CAL_W'($urandom);
      endcase
   endfunction

   task automatic drain();
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // calibration changes only with the pipeline empty
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CAL_W-1:0] data);
      if (req_on) begin
         start <= 1'b0;
         req_on = 1'b0;
         drain();
      end
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx <= CSR_TEMPSENS)
         cal_shadow[idx] = data;
      csr_on = 1'b1;
   endtask

   task automatic issue_reading(input logic [RAW_W-1:0] p, input logic [RAW_W-1:0] t,
                                input logic signed [BIAS_W-1:0] b, input bit typed,
                                input logic signed [TEMP_W-1:0] et,
                                input logic signed [PRES_W-1:0] ep);
      reading_type want;
      if (csr_on) begin
         csr_valid <= 1'b0;
         csr_on = 1'b0;
      end
      if (gaps_on && $urandom_range(99) < 4) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      start              <= 1'b1;
      req_raw_pres       <= p;
      req_raw_temp       <= t;
      req_pres_bias_mbar <= b;
      do @(posedge clock); while (busy);
      if (typed) begin
         want.temp_centi = et;
         want.pressure   = ep;
      end else begin
         want = compensate(p, t, b);
      end
      pending_readings.push_back(want);
      req_on = 1'b1;
   endtask

   // results cannot be held off: check every strobed transaction
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_readings.size() == 0) begin
            $display("%0t: unexpected result temp_centi %0d pressure %0d",
                     $time, rsp_temp_centi, rsp_pressure);
            errors++;
         end else begin
            head = pending_readings.pop_front();
            if (rsp_temp_centi !== head.temp_centi) begin
               $display("%0t: temp_centi expected %0d actual %0d",
                        $time, head.temp_centi, rsp_temp_centi);
               errors++;
            end
            if (rsp_pressure !== head.pressure) begin
               $display("%0t: pressure expected %0d actual %0d",
                        $time, head.pressure, rsp_pressure);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
   end

   initial begin
      wait (stall_cycles >= STALL_LIMIT);
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      foreach (cal_shadow[i]) cal_shadow[i] = '0;

      // zero calibration: temperature sits at 2000, pressure is minus the bias
      add_reading('0, '0, 16'sd0, 1'b1, 19'sd2000, 18'sd0);
      add_reading('1, '1, 16'sh8000, 1'b1, 19'sd2000, 18'sd32768);
      add_reading('0, '1, 16'sh7FFF, 1'b1, 19'sd2000, -18'sd32767);
      add_csr(CSR_IDX_SPARE0, 16'hFFFF);
      add_csr(CSR_IDX_SPARE1, 16'hFFFF);
      add_reading(24'hAAAAAA, 24'h555555, 16'sh5555, 1'b1, 19'sd2000, -18'sd21845);
      add_reading(24'h555555, 24'hAAAAAA, 16'shAAAA, 1'b1, 19'sd2000, 18'sd21846);
      add_reading(24'h123456, 24'h654321, 16'sd100, 1'b1, 19'sd2000, -18'sd100);
      // typical calibration set
      add_csr(CSR_SENS_T1, 16'd46372);
      add_csr(CSR_OFF_T1, 16'd43981);
      add_csr(CSR_TCS, 16'd29059);
      add_csr(CSR_TCO, 16'd27842);
      add_csr(CSR_TREF, 16'd31553);
      add_csr(CSR_TEMPSENS, 16'd28165);
      add_csr(CSR_IDX_SPARE1, 16'h0000);
      add_reading(24'd6465444, 24'd8077636, 16'sd0, 1'b0, '0, '0);
      add_reading('0, '0, 16'sd0, 1'b0, '0, '0);
      add_reading('1, '1, 16'sh8000, 1'b0, '0, '0);
      add_reading('1, '0, 16'sh7FFF, 1'b0, '0, '0);
      add_reading('0, '1, 16'sd0, 1'b0, '0, '0);
      // every word at full scale
      add_csr(CSR_SENS_T1, 16'hFFFF);
      add_csr(CSR_OFF_T1, 16'hFFFF);
      add_csr(CSR_TCS, 16'hFFFF);
      add_csr(CSR_TCO, 16'hFFFF);
      add_csr(CSR_TREF, 16'hFFFF);
      add_csr(CSR_TEMPSENS, 16'hFFFF);
      add_reading('1, '0, 16'sd0, 1'b0, '0, '0);
      add_reading('1, '1, 16'sd0, 1'b0, '0, '0);
      add_reading('0, '0, -16'sd1, 1'b0, '0, '0);
      add_reading(24'h800000, 24'h800000, 16'sd1, 1'b0, '0, '0);

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         if (directed[i].is_csr)
            csr_write(directed[i].index, directed[i].wdata);
         else
            issue_reading(directed[i].raw_pres, directed[i].raw_temp, directed[i].bias,
                          directed[i].typed, directed[i].temp_centi, directed[i].pressure);
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         if ($urandom_range(2) == 0)
            csr_write($urandom_range(1) ? CSR_IDX_SPARE0 : CSR_IDX_SPARE1, CAL_W'($urandom));
         for (int r = CSR_SENS_T1; r <= CSR_TEMPSENS; r++)
            csr_write(r[CSR_IDX_W-1:0], pick_cal());
         // one phase runs back to back with no gaps
         gaps_on = (ph != 2);
         repeat (PHASE_ITEMS)
            issue_reading(pick_raw(), pick_raw(), pick_bias(), 1'b0, '0, '0);
      end

      if (csr_on)
         csr_valid <= 1'b0;
      start <= 1'b0;
      drain();

      if (errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
